/* src/modulated_delay_line_interp_defines.svh */
// Assertion macros used by the delay line top module.
// Each macro checks on the rising edge of i_clk and is disabled during reset.
`ifndef MODULATED_DELAY_LINE_INTERP_DEFINES_SVH
`define MODULATED_DELAY_LINE_INTERP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MDLI_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define MDLI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* src/mdli_pkg.sv */
`default_nettype none

package mdli_pkg;

    // Fixed field widths.
    localparam int CFG_W     = 12;
    localparam int MOD_W     = 16;
    localparam int FRAC_BITS = 16;

    // Register port geometry: one 32-bit register at byte address zero.
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;
    localparam int REG_IDX_LSB = 2;

    typedef logic [PADDR_W-1:REG_IDX_LSB] t_reg_idx;

    localparam t_reg_idx REG_DELAY_LENGTH = 1'b0;

    // Sequencer states, one-hot.
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MUL  = 7'b0000010,
        S_ADDR = 7'b0000100,
        S_RD0  = 7'b0001000,
        S_RD1  = 7'b0010000,
        S_MIX  = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

endpackage

`default_nettype wire

/* src/mdli_ram.sv */
`default_nettype none

module mdli_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* src/mdli_regs.sv */
`default_nettype none

module mdli_regs
    import mdli_pkg::*;
#(
    parameter int MAX_DEPTH = 2048
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [PADDR_W-1:0]            paddr,
    input  wire logic [PDATA_W-1:0]            pwdata,
    output logic      [PDATA_W-1:0]            prdata,
    output logic                               pready,
    output logic      [$clog2(MAX_DEPTH+1)-1:0] o_len
);

    localparam int LW = $clog2(MAX_DEPTH + 1);
    localparam int CW = (LW > CFG_W) ? LW : CFG_W;

    logic [CW-1:0] r_len;
    t_reg_idx      reg_idx;
    logic          wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:REG_IDX_LSB];
    assign wr_en   = psel && penable && pwrite && pready;

    // Length register; writes keep the low field bits only.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= CW'(MAX_DEPTH);
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_DELAY_LENGTH: r_len <= CW'(pwdata[CFG_W-1:0]);
                default: ;
            endcase
        end
    end

    // Read-back decoder.
    always_comb begin
        unique case (reg_idx)
            REG_DELAY_LENGTH: prdata = PDATA_W'(r_len);
            default:          prdata = '0;
        endcase
    end

    // Lengths beyond the store depth act as the full depth.
    assign o_len = (r_len > CW'(MAX_DEPTH)) ? LW'(MAX_DEPTH) : r_len[LW-1:0];

endmodule

`default_nettype wire

/* src/modulated_delay_line_interp.sv */
// Each result is registered on the output as the sequencer leaves S_OUT; no new word is
// taken before it is back in S_IDLE. The sequencer writes the delay memory and then
// reads both taps one after the other through its single registered read port.
// Reset: sequencer idle, write pointer and fill count zero, length register at MAX_DEPTH.
// The delay memory is not swept; entries at or above the fill count read as zero.
`default_nettype none

`include "modulated_delay_line_interp_defines.svh"

module modulated_delay_line_interp
    import mdli_pkg::*;
#(
    parameter int MAX_DEPTH   = 2048,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [PADDR_W-1:0]            paddr,
    input  wire logic [PDATA_W-1:0]            pwdata,
    output logic      [PDATA_W-1:0]            prdata,
    output logic                               pready,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample_in,
    input  wire logic signed [MOD_W-1:0]       i_modulation,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic signed [SAMPLE_BITS-1:0]      o_sample_out
);

    localparam int LW = $clog2(MAX_DEPTH + 1);
    localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int PW = MOD_W + LW + 1;
    localparam int NW = PW - FRAC_BITS;
    localparam int DW = LW + 2;
    localparam int FW = FRAC_BITS + 1;
    localparam int SW = SAMPLE_BITS;
    localparam int XW = SW + 1;
    localparam int MW = FW + XW;
    localparam int TW = MW + 1;
    localparam int QW = TW - FRAC_BITS;

    // Control state.
    t_state             r_state, n_state;
    logic [LW-1:0]      r_wp;
    logic [LW-1:0]      r_fill;
    logic               r_out_valid;

    // Payload state.
    logic signed [SW-1:0]    r_smp;
    logic signed [MOD_W-1:0] r_mod;
    logic [LW-1:0]           r_len;
    logic [AW-1:0]           r_wcur;
    logic signed [PW-1:0]    r_p;
    logic [AW-1:0]           r_idx;
    logic [AW-1:0]           r_nxt;
    logic signed [FW-1:0]    r_f;
    logic signed [SW-1:0]    r_a;
    logic                    r_a_ok;
    logic                    r_b_ok;
    logic signed [SW-1:0]    r_b;
    logic signed [MW-1:0]    r_prod;
    logic signed [SW-1:0]    r_out;

    // Combinational terms.
    logic [LW-1:0]        len_cfg;
    logic                 in_acc;
    logic                 out_free;
    logic [LW-1:0]        wp_eff;
    logic [LW-1:0]        wp_next;
    logic signed [NW-1:0] p_hi;
    logic                 neg_frac;
    logic signed [NW-1:0] tap_n;
    logic signed [DW-1:0] tap_d;
    logic signed [DW-1:0] idx_raw;
    logic signed [DW-1:0] idx_wrap;
    logic [LW:0]          nxt_inc;
    logic [AW-1:0]        nxt_wrap;
    logic [AW-1:0]        ram_raddr;
    logic [SW-1:0]        ram_rdata;
    logic signed [SW-1:0] tap_a;
    logic signed [SW-1:0] tap_b;
    logic signed [XW-1:0] tap_diff;
    logic signed [TW-1:0] b_ext;
    logic signed [TW-1:0] prod_ext;
    logic signed [TW-1:0] c_half;
    logic signed [TW-1:0] mix_sum;
    logic [QW-1:0]        mix_q;
    logic signed [SW-1:0] mix_sat;

    mdli_regs #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_len   (len_cfg)
    );

    mdli_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (r_state == S_MUL),
        .i_waddr (r_wcur),
        .i_wdata (r_smp),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Handshake terms.
    assign o_in_stall   = (r_state != S_IDLE);
    assign in_acc       = i_in_valid && !o_in_stall;
    assign out_free     = !r_out_valid || !i_out_stall;
    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out;

    // The pointer restarts at zero once it reaches the active length.
    assign wp_eff  = (r_wp >= len_cfg) ? '0 : r_wp;
    assign wp_next = LW'(r_wcur) + LW'(1);

    // Split the tap product into a truncated integer part and a signed fraction.
    assign p_hi     = r_p[PW-1:FRAC_BITS];
    assign neg_frac = r_p[PW-1] && (r_p[FRAC_BITS-1:0] != '0);
    assign tap_n    = neg_frac ? (p_hi + NW'(1)) : p_hi;
    assign tap_d    = $signed({2'b00, r_len >> 1}) + $signed({tap_n[NW-1], tap_n});
    assign idx_raw  = $signed({{(DW-AW){1'b0}}, r_wcur}) - tap_d;
    assign idx_wrap = idx_raw[DW-1] ? (idx_raw + $signed({2'b00, r_len})) : idx_raw;

    // Neighbor index wraps to zero at the active length.
    assign nxt_inc  = (LW + 1)'(r_idx) + (LW + 1)'(1);
    assign nxt_wrap = (nxt_inc >= {1'b0, r_len}) ? '0 : nxt_inc[AW-1:0];

    assign ram_raddr = (r_state == S_RD1) ? r_nxt : r_idx;

    // Entries never written read as zero.
    assign tap_a    = r_a_ok ? r_a : '0;
    assign tap_b    = r_b_ok ? $signed(ram_rdata) : '0;
    assign tap_diff = $signed({tap_a[SW-1], tap_a}) - $signed({tap_b[SW-1], tap_b});

    // Blend, round half up, then saturate to the sample range.
    assign b_ext    = {{(TW-SW){r_b[SW-1]}}, r_b};
    assign prod_ext = {{(TW-MW){r_prod[MW-1]}}, r_prod};
    assign c_half   = {{(TW-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
    assign mix_sum  = (b_ext <<< FRAC_BITS) + prod_ext + c_half;
    assign mix_q    = mix_sum[TW-1:FRAC_BITS];

    always_comb begin
        if (mix_q[QW-1:SW-1] == '0 || mix_q[QW-1:SW-1] == '1) begin
            mix_sat = $signed(mix_q[SW-1:0]);
        end else if (mix_q[QW-1]) begin
            mix_sat = $signed({1'b1, {(SW-1){1'b0}}});
        end else begin
            mix_sat = $signed({1'b0, {(SW-1){1'b1}}});
        end
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (in_acc) n_state = S_MUL;
            S_MUL:  n_state = S_ADDR;
            S_ADDR: n_state = S_RD0;
            S_RD0:  n_state = S_RD1;
            S_RD1:  n_state = S_MIX;
            S_MIX:  n_state = S_OUT;
            S_OUT:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers: state, pointer, fill count and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wp        <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_MUL) begin
                r_wp <= wp_next;
                if (wp_next > r_fill) begin
                    r_fill <= wp_next;
                end
            end
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers, loaded step by step as the sequencer advances.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_smp  <= i_sample_in;
            r_mod  <= i_modulation;
            r_len  <= len_cfg;
            r_wcur <= wp_eff[AW-1:0];
        end
        if (r_state == S_MUL) begin
            r_p <= PW'(r_mod) * PW'($signed({1'b0, r_len}));
        end
        if (r_state == S_ADDR) begin
            r_idx <= idx_wrap[AW-1:0];
            r_f   <= $signed({neg_frac, r_p[FRAC_BITS-1:0]});
        end
        if (r_state == S_RD0) begin
            r_nxt  <= nxt_wrap;
            r_a_ok <= (LW'(r_idx) < r_fill);
        end
        if (r_state == S_RD1) begin
            r_a    <= $signed(ram_rdata);
            r_b_ok <= (LW'(r_nxt) < r_fill);
        end
        if (r_state == S_MIX) begin
            r_b    <= tap_b;
            r_prod <= MW'(r_f) * MW'(tap_diff);
        end
        if (r_state == S_OUT && out_free) begin
            r_out <= mix_sat;
        end
    end

    // An accepted word holds off the next one.
    `MDLI_ASSERT_NEXT(a_accept_blocks, in_acc, o_in_stall)
    // Every written entry lies below the fill count.
    `MDLI_ASSERT_SAME(a_wp_in_fill, 1'b1, (r_wp <= r_fill) && (r_fill <= LW'(MAX_DEPTH)))
    // The first tap always lands inside the active length when that length is nonzero.
    `MDLI_ASSERT_SAME(a_idx_in_len, r_state == S_RD0, (LW'(r_idx) < r_len) || (r_len == '0))
    // A new result appears only out of the final step.
    `MDLI_ASSERT_SAME(a_out_from_seq, $rose(r_out_valid), $past(r_state == S_OUT))

endmodule

`default_nettype wire

/* tb/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mdli_pkg::*;

    localparam int DEPTH       = 2048;
    localparam int SBITS       = 16;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE      = 8;

    // Register index that decodes to nothing; writes there must be ignored.
    localparam t_reg_idx REG_SPARE = 1'b1;

    localparam logic [PADDR_W-1:0] ADDR_LENGTH = PADDR_W'(REG_DELAY_LENGTH) << REG_IDX_LSB;
    localparam logic [PADDR_W-1:0] ADDR_SPARE  = PADDR_W'(REG_SPARE) << REG_IDX_LSB;

    // Tracks the delay line contents and predicts every interpolated tap.
    class tap_scoreboard;
        logic signed [SBITS-1:0] line_mem [DEPTH];
        logic signed [SBITS-1:0] pending_taps [$];
        logic [CFG_W-1:0]        length_reg;
        int                      wr_ptr;
        int                      taken;
        int                      checked;
        int                      errors;

        function new();
            foreach (line_mem[i]) line_mem[i] = '0;
            length_reg = CFG_W'(DEPTH);
            wr_ptr     = 0;
            taken      = 0;
            checked    = 0;
            errors     = 0;
        endfunction

        function void set_length(logic [CFG_W-1:0] value);
            length_reg = value;
        endfunction

        // Write the sample, then blend the two entries around the modulated tap.
        function void take_sample(logic signed [SBITS-1:0] smp, logic signed [MOD_W-1:0] modv);
            int                      len;
            int                      m;
            int                      p;
            int                      n;
            int                      f;
            int                      d;
            int                      idx;
            int                      nxt;
            longint                  a;
            longint                  b;
            longint                  t;
            logic signed [SBITS-1:0] tap;
            len = int'(length_reg);
            if (len > DEPTH) len = DEPTH;
            if (wr_ptr >= len) wr_ptr = 0;
            if (wr_ptr < DEPTH) line_mem[wr_ptr] = smp;

            // Integer part truncates toward zero; the fraction keeps the sign.
            m = int'(modv);
            p = m * len;
            n = p / 65536;
            f = p - n * 65536;
            d = len / 2 + n;
            idx = wr_ptr - d;
            if (idx < 0) idx += len;
            nxt = idx + 1;
            if (nxt >= len) nxt = 0;
            a = (idx >= 0 && idx < DEPTH) ? longint'(line_mem[idx]) : 0;
            b = (nxt >= 0 && nxt < DEPTH) ? longint'(line_mem[nxt]) : 0;

            // Round half up, then clamp to the sample range.
            t = b * 65536 + longint'(f) * (a - b) + 32768;
            t = t >>> FRAC_BITS;
            if (t > 32767) t = 32767;
            if (t < -32768) t = -32768;
            tap = t[SBITS-1:0];
            pending_taps.push_back(tap);
            wr_ptr++;
            taken++;
        endfunction

        function void check_tap(logic signed [SBITS-1:0] got);
            logic signed [SBITS-1:0] want;
            checked++;
            if (pending_taps.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: output word %0d with no input word pending", $time, got);
                return;
            end
            want = pending_taps.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: output word %0d mismatch, expected %0d got %0d",
                             $time, checked, want, got);
            end
        endfunction
    endclass

    logic                     i_clk;
    logic                     i_rst_n      = 1'b0;
    logic                     psel         = 1'b0;
    logic                     penable      = 1'b0;
    logic                     pwrite       = 1'b0;
    logic [PADDR_W-1:0]       paddr        = '0;
    logic [PDATA_W-1:0]       pwdata       = '0;
    logic [PDATA_W-1:0]       prdata;
    logic                     pready;
    logic                     i_in_valid   = 1'b0;
    logic                     o_in_stall;
    logic signed [SBITS-1:0]  i_sample_in  = '0;
    logic signed [MOD_W-1:0]  i_modulation = '0;
    logic                     o_out_valid;
    logic                     i_out_stall  = 1'b0;
    logic signed [SBITS-1:0]  o_sample_out;

    // Set for the closing stretch of the run, where neither side idles.
    bit                       calm         = 1'b0;
    int                       gap_pct      = 20;
    int                       settings_used = 0;
    tap_scoreboard            sb;

    wire sample_fire = i_in_valid && !o_in_stall;
    wire tap_fire    = o_out_valid && !i_out_stall;

    modulated_delay_line_interp #(
        .MAX_DEPTH  (DEPTH),
        .SAMPLE_BITS(SBITS)
    ) u_dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hand accepted words to the scoreboard.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (sample_fire) sb.take_sample(i_sample_in, i_modulation);
            if (tap_fire) sb.check_tap(o_sample_out);
        end
    end

    // Output stall in random bursts, with some stretches left free.
    initial begin : out_stall_gen
        int stretch;
        int odds;
        forever begin
            stretch = $urandom_range(20, 200);
            odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
            while (stretch > 0) begin
                @(posedge i_clk);
                stretch--;
                if (!calm && $urandom_range(0, 99) < odds) begin
                    i_out_stall <= 1'b1;
                    repeat ($urandom_range(1, 9)) @(posedge i_clk);
                    i_out_stall <= 1'b0;
                end
            end
        end
    end

    // End the run if no word moves on either side for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if (sample_fire || tap_fire) quiet = 0;
            else quiet++;
        end
        $display("Watchdog: no word moved for %0d cycles", STALL_LIMIT);
        $display("[modulated_delay_line_interp] ERROR");
        $finish;
    end

    // Offer one input word, with an optional idle burst in front of it.
    task automatic send_sample(input logic signed [SBITS-1:0] smp,
                               input logic signed [MOD_W-1:0] modv);
        if (!calm && $urandom_range(0, 99) < gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_sample_in  <= smp;
        i_modulation <= modv;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Drop valid and wait until every predicted word has come out.
    task automatic drain_line();
        i_in_valid <= 1'b0;
        while (sb.pending_taps.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Setup and access cycle; the write lands on the access edge.
    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr[PADDR_W-1:REG_IDX_LSB] == REG_DELAY_LENGTH) begin
            sb.set_length(data[CFG_W-1:0]);
            settings_used++;
        end
    endtask

    initial begin : stimulus
        logic signed [SBITS-1:0] smp;
        logic signed [MOD_W-1:0] modv;
        logic [CFG_W-1:0]        len;
        int                      count;
        sb = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Full length after reset: taps at both ends and saturation both ways.
        send_sample(16'sh7fff, 16'sh8000);
        send_sample(16'sh8000, 16'sh8001);
        send_sample(16'sh7fff, 16'sh8001);
        send_sample(16'sh8000, 16'sh7fff);
        send_sample(16'sh0000, 16'sh0000);
        send_sample(16'sh0001, 16'sh0001);
        send_sample(16'shffff, 16'shffff);
        drain_line();

        // Short odd length with junk in the upper data bits; pointer wraps back.
        apb_write(ADDR_SPARE, 32'h0000_0010);
        @(posedge i_clk);
        apb_write(ADDR_LENGTH, 32'hffff_f003);
        send_sample(16'sh1234, 16'sh8000);
        send_sample(16'sh8000, 16'sh7fff);
        send_sample(16'sh7fff, 16'sh4000);
        send_sample(16'sh5555, 16'shc000);
        drain_line();

        // Zero length passes the sample straight through.
        apb_write(ADDR_LENGTH, 32'h0000_0000);
        send_sample(16'sh3039, 16'sh7fff);
        send_sample(16'sh8000, 16'sh8000);
        send_sample(16'sh7fff, 16'sh0000);
        drain_line();

        apb_write(ADDR_LENGTH, 32'h0000_0001);
        send_sample(16'shffff, 16'sh2ee0);
        send_sample(16'sh0002, 16'shec78);
        drain_line();

        // Length above the store size acts as the full store.
        apb_write(ADDR_LENGTH, 32'h0000_0fff);
        send_sample(16'sh7fff, 16'sh8000);
        send_sample(16'sh8000, 16'sh8001);
        send_sample(16'sh2aaa, 16'sh7fff);
        drain_line();

        // Random phases, each under its own length and idle pattern.
        for (int ph = 0; ph < 10; ph++) begin
            case ($urandom_range(0, 9))
                0:       len = '0;
                1:       len = CFG_W'(1);
                2:       len = CFG_W'(2);
                3:       len = CFG_W'($urandom_range(3, 16));
                4:       len = CFG_W'($urandom_range(17, 300));
                5:       len = CFG_W'($urandom_range(301, 2047));
                6:       len = CFG_W'(DEPTH);
                7:       len = CFG_W'($urandom_range(2049, 4095));
                8:       len = CFG_W'(4095);
                default: len = CFG_W'($urandom_range(2, 64));
            endcase
            apb_write(ADDR_LENGTH, {20'($urandom()), len});
            calm    = (ph == 9);
            gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 50);
            count   = $urandom_range(80, 120);
            for (int k = 0; k < count; k++) begin
                case ($urandom_range(0, 7))
                    0:       smp = 16'sh7fff;
                    1:       smp = 16'sh8000;
                    2:       smp = 16'($urandom_range(0, 255) - 128);
                    default: smp = 16'($urandom());
                endcase
                // Lean toward taps near the newest words, so long lines read live data, and near the oldest.
                case ($urandom_range(0, 9)) inside
                    0:       modv = 16'sh8000;
                    1:       modv = 16'sh7fff;
                    2:       modv = 16'sh0000;
                    [3:4]:   modv = 16'(-32768 + $urandom_range(0, 4000));
                    5:       modv = 16'(32767 - $urandom_range(0, 4000));
                    default: modv = 16'($urandom());
                endcase
                send_sample(smp, modv);
            end
            drain_line();
        end

        repeat (4) @(posedge i_clk);
        $display("Run covered %0d input words and %0d output words over %0d length settings.",
                 sb.taken, sb.checked, settings_used);
        $display("Lengths ranged over zero, one, short, full and above full; %0d errors.",
                 sb.errors + sb.pending_taps.size());
        if (sb.errors == 0 && sb.pending_taps.size() == 0) begin
            $display("[modulated_delay_line_interp] OK");
        end else begin
            $display("[modulated_delay_line_interp] ERROR");
        end
        $finish;
    end

endmodule
